// ===== rtl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
// No dependencies; every other file of the block but ffha_ram imports this package.
package ffha_pkg;

  localparam int HEAP_WORDS = 1024;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int BYTES_W    = 14;
  localparam int WORD_SHIFT = 3;
  localparam int WORD_BYTES = 1 << WORD_SHIFT;
  localparam int WANT_W     = BYTES_W - WORD_SHIFT + 1;
  localparam int SUM_W      = WANT_W + 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_ZERO    = 2'd3
  } ffha_status_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              alloced;
    logic              zero_mark;
  } ffha_hdr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_address;
    ffha_status_t      status;
  } ffha_res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_RD,
    S_WALK_EV,
    S_SPLIT,
    S_MARK,
    S_FREE_EV,
    S_DONE
  } ffha_state_t;

endpackage

// ===== rtl/ffha_if.sv =====
// Request and result channel interfaces of the first-fit heap allocator.
// Depends on ffha_pkg for field widths.
interface ffha_in_if import ffha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [BYTES_W-1:0] request_bytes;
  logic [ADDR_W-1:0]  free_address;

  modport source (output valid, operation, request_bytes, free_address, input ready);
  modport sink   (input valid, operation, request_bytes, free_address, output ready);
endinterface

interface ffha_out_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] payload_address;
  logic [1:0]        status;

  modport source (output valid, payload_address, status, input ready);
  modport sink   (input valid, payload_address, status, output ready);
endinterface

// ===== rtl/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ffha_core.sv =====
// Sequencer of the allocator: clearing pass, header walk, split, mark and free.
// Depends on ffha_pkg, ffha_if and ffha_ram (header store).
module ffha_core import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ffha_in_if.sink    in_ch,
  output logic       res_valid,
  input  logic       res_ready,
  output ffha_res_t  res
);

  ffha_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SUM_W-1:0]  passed_r, passed_nxt;
  logic [WANT_W-1:0] want_r, want_nxt;
  logic [SIZE_W-1:0] hsize_r, hsize_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  ffha_res_t         res_r, res_nxt;

  // header store port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  ffha_hdr_t         ram_wdata, rd_hdr;
  logic [$bits(ffha_hdr_t)-1:0] ram_rdata;

  logic              accept;
  logic [BYTES_W:0]  bytes_up;
  logic [WANT_W-1:0] want_in;
  logic [SUM_W-1:0]  limit_sum;
  logic              over_limit, past_end;
  logic              untouched, fits;
  logic [IDX_W-1:0]  payload;
  logic [SUM_W-1:0]  grant_room;
  logic              grant_bad;
  logic [SUM_W-1:0]  nxt_hdr;
  logic              do_split;
  logic [SIZE_W-1:0] rest;

  ffha_ram #(
    .WIDTH($bits(ffha_hdr_t)),
    .DEPTH(HEAP_WORDS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_hdr      = ffha_hdr_t'(ram_rdata);
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // round the byte count up to whole words
  assign bytes_up = {1'b0, in_ch.request_bytes} + (BYTES_W+1)'(WORD_BYTES - 1);
  assign want_in  = bytes_up[BYTES_W:WORD_SHIFT];

  assign limit_sum  = passed_r + SUM_W'(want_r);
  assign over_limit = limit_sum > SUM_W'(HEAP_WORDS - 2);
  assign past_end   = idx_r >= IDX_W'(HEAP_WORDS);

  assign untouched  = (rd_hdr.size == '0) && !rd_hdr.zero_mark;
  assign fits       = !rd_hdr.alloced && (WANT_W'(rd_hdr.size) >= want_r);
  assign payload    = idx_r + IDX_W'(1);
  assign grant_room = SUM_W'(HEAP_WORDS) - SUM_W'(payload);
  assign grant_bad  = SUM_W'(want_r) > grant_room;
  assign nxt_hdr    = SUM_W'(idx_r) + SUM_W'(want_r) + SUM_W'(1);
  assign do_split   = (WANT_W'(rd_hdr.size) > want_r) && (nxt_hdr < SUM_W'(HEAP_WORDS));
  assign rest       = hsize_r - SIZE_W'(want_r) - SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    passed_r <= passed_nxt;
    want_r   <= want_nxt;
    hsize_r  <= hsize_nxt;
    res_r    <= res_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == ADDR_W'(HEAP_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_ch.operation == OP_FREE) begin
            state_nxt = (in_ch.free_address == '0) ? S_DONE : S_FREE_EV;
          end else begin
            state_nxt = (in_ch.request_bytes == '0) ? S_DONE : S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        state_nxt = (past_end || over_limit) ? S_DONE : S_WALK_EV;
      end
      S_WALK_EV: begin
        if (untouched || fits) begin
          if (grant_bad)     state_nxt = S_DONE;
          else if (do_split) state_nxt = S_SPLIT;
          else               state_nxt = S_MARK;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_SPLIT:   state_nxt = S_MARK;
      S_MARK:    state_nxt = S_DONE;
      S_FREE_EV: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    idx_nxt    = idx_r;
    passed_nxt = passed_r;
    want_nxt   = want_r;
    hsize_nxt  = hsize_r;
    clr_nxt    = clr_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r[ADDR_W-1:0];
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[ADDR_W-1:0];
    res_valid  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + ADDR_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          res_nxt.payload_address = '0;
          idx_nxt    = '0;
          passed_nxt = '0;
          want_nxt   = want_in;
          if (in_ch.operation == OP_FREE) begin
            res_nxt.status = ST_BADFREE;
            idx_nxt        = IDX_W'(in_ch.free_address) - IDX_W'(1);
            ram_re         = (in_ch.free_address != '0);
            ram_raddr      = in_ch.free_address - ADDR_W'(1);
          end else begin
            res_nxt.status = ST_ZERO;
          end
        end
      end
      S_WALK_RD: begin
        res_nxt.status = ST_NOMEM;
        ram_re         = !(past_end || over_limit);
      end
      S_WALK_EV: begin
        hsize_nxt = rd_hdr.size;
        if (!(untouched || fits)) begin
          // step over this block and its header
          passed_nxt = passed_r + SUM_W'(rd_hdr.size);
          idx_nxt    = idx_r + IDX_W'(rd_hdr.size) + IDX_W'(1);
        end
      end
      S_SPLIT: begin
        ram_we              = 1'b1;
        ram_waddr           = nxt_hdr[ADDR_W-1:0];
        ram_wdata.size      = rest;
        ram_wdata.alloced   = 1'b0;
        ram_wdata.zero_mark = (rest == '0);
      end
      S_MARK: begin
        ram_we                  = 1'b1;
        ram_wdata.size          = SIZE_W'(want_r);
        ram_wdata.alloced       = 1'b1;
        ram_wdata.zero_mark     = 1'b0;
        res_nxt.status          = ST_OK;
        res_nxt.payload_address = payload[ADDR_W-1:0];
      end
      S_FREE_EV: begin
        if (rd_hdr.size != '0 && rd_hdr.alloced) begin
          ram_we            = 1'b1;
          ram_wdata         = rd_hdr;
          ram_wdata.alloced = 1'b0;
          res_nxt.status    = ST_OK;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

endmodule

// ===== rtl/ffha_out.sv =====
// Result register of the allocator: holds one result until the sink takes it.
// Depends on ffha_pkg and ffha_if.
module ffha_out import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  output logic       res_ready,
  input  ffha_res_t  res,
  ffha_out_if.source out_ch
);

  logic      out_valid_r, out_valid_nxt;
  ffha_res_t out_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
    else if (out_ch.ready)      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.payload_address = out_r.payload_address;
  assign out_ch.status          = out_r.status;

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over an implicit list of block headers, one
// header word in front of each block in a heap of HEAP_WORDS words held in a
// single-port-read RAM. After reset the block runs a clearing pass over all
// HEAP_WORDS header words with ready low. An allocate takes the request, then
// walks the headers from word 0, each header visited with a RAM read, then a
// compare and advance, then splits, marks and reports as needed, so its latency
// grows with the number of blocks in front of the chosen one. A free reads the
// header in front of the payload and clears its allocated bit if set; a free of
// payload offset 0 and a zero-byte request go straight to the report. One
// request is worked at a time; a finished result sits in an output register so
// the next request can start before the result is taken.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ffha_in_if.sink    in_ch,
  ffha_out_if.source out_ch
);

  logic      res_valid;
  logic      res_ready;
  ffha_res_t res;

  ffha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ffha_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/ffha_chk.sv =====
// Port-level checks of the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator.
module ffha_chk import ffha_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_payload_address,
  input logic [1:0]        out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_address)
      && $stable(out_status))
    else $error("result changed while stalled");

  a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_payload_address == '0)
    else $error("error result carries a nonzero address");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after a request");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready high during clearing pass");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_payload_address (out_ch.payload_address),
  .out_status          (out_ch.status)
);

// ===== bench/ffha_checker.sv =====
// Scoreboard for the first-fit heap allocator: mirrors the header store,
// predicts each reply and compares it with the result channel.
// Depends on ffha_pkg and the ffha_in_if / ffha_out_if interfaces.
`timescale 1ns / 1ps

module ffha_checker import ffha_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ffha_in_if   in_ch,
  ffha_out_if  out_ch,
  output int   mismatches,
  output int   awaiting
);

  ffha_hdr_t heap_hdr [HEAP_WORDS];
  ffha_res_t expected_replies [$];

  initial begin
    foreach (heap_hdr[i]) heap_hdr[i] = '0;
  end

  // Work out the reply to one request and update the mirrored headers.
  function automatic ffha_res_t heap_answer(input logic op,
                                            input logic [BYTES_W-1:0] nbytes,
                                            input logic [ADDR_W-1:0] faddr);
    ffha_res_t   reply;
    ffha_hdr_t   hdr;
    int unsigned want, idx, passed, rest, nxt;
    bit          found;
    reply.payload_address = '0;
    reply.status          = ST_OK;
    hdr                   = '0;
    found                 = 1'b0;
    idx                   = 0;
    passed                = 0;
    if (op == OP_FREE) begin
      if (faddr == '0) begin
        reply.status = ST_BADFREE;
      end else begin
        hdr = heap_hdr[faddr - 1];
        if (hdr.size == '0 || !hdr.alloced) begin
          reply.status = ST_BADFREE;
        end else begin
          heap_hdr[faddr - 1].alloced = 1'b0;
        end
      end
    end else if (nbytes == '0) begin
      reply.status = ST_ZERO;
    end else begin
      want = (int'(nbytes) + WORD_BYTES - 1) >> WORD_SHIFT;
      // Walk headers; zero-size remainder blocks (zero_mark set) are touched but never fit.
      while (!found && idx < HEAP_WORDS && passed + want <= HEAP_WORDS - 2) begin
        hdr = heap_hdr[idx];
        if ((hdr.size == '0 && !hdr.zero_mark) || (!hdr.alloced && hdr.size >= want)) begin
          found = 1'b1;
        end else begin
          passed += hdr.size;
          idx    += hdr.size + 1;
        end
      end
      if (!found || want > HEAP_WORDS - (idx + 1)) begin
        reply.status = ST_NOMEM;
      end else begin
        if (hdr.size > want) begin
          rest = hdr.size - want - 1;
          nxt  = idx + want + 1;
          if (nxt < HEAP_WORDS) begin
            heap_hdr[nxt].size      = SIZE_W'(rest);
            heap_hdr[nxt].zero_mark = (rest == 0);
            heap_hdr[nxt].alloced   = 1'b0;
          end
        end
        heap_hdr[idx].size      = SIZE_W'(want);
        heap_hdr[idx].zero_mark = 1'b0;
        heap_hdr[idx].alloced   = 1'b1;
        reply.payload_address   = ADDR_W'(idx + 1);
      end
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    ffha_res_t want_reply;
    if (rst_n) begin
      // A reply can never belong to a request taken on the same edge: compare first.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reply payload_address=%0d status=%0d",
                   $time, out_ch.payload_address, out_ch.status);
        end else begin
          want_reply = expected_replies.pop_front();
          if (out_ch.payload_address !== want_reply.payload_address) begin
            mismatches++;
            $display("%0t: payload_address expected %0d actual %0d",
                     $time, want_reply.payload_address, out_ch.payload_address);
          end
          if (out_ch.status !== want_reply.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want_reply.status, out_ch.status);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_replies.push_back(heap_answer(in_ch.operation, in_ch.request_bytes,
                                               in_ch.free_address));
      end
    end
    awaiting <= expected_replies.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the first-fit heap allocator bench: clock, reset, request and
// ready stimulus, verdict. Depends on ffha_pkg, the channel interfaces,
// ffha_checker and first_fit_heap_allocator.
`timescale 1ns / 1ps

module testbench import ffha_pkg::*;;

  localparam int RANDOM_REQUESTS = 1875;
  localparam longint CYCLE_LIMIT = 20_000_000;

  logic clk;
  logic rst_n;
  bit   calm;
  int   mismatches;
  int   awaiting;
  longint cycle_count;

  logic [ADDR_W-1:0] live_addrs [$];
  logic [ADDR_W-1:0] last_freed;

  ffha_in_if  in_ch ();
  ffha_out_if out_ch ();

  first_fit_heap_allocator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ffha_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** first_fit_heap_allocator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  // Remember granted payloads so most frees hit live blocks.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.status == ST_OK &&
        out_ch.payload_address != '0)
      live_addrs.push_back(out_ch.payload_address);
  end

  task automatic issue(input logic op, input int nbytes, input int faddr);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.request_bytes <= BYTES_W'(nbytes);
    in_ch.free_address  <= ADDR_W'(faddr);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold off until every outstanding reply has come back.
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int k;
    int nbytes;
    rst_n               <= 1'b0;
    calm                 = 1'b0;
    last_freed           = '0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_ALLOC;
    in_ch.request_bytes <= '0;
    in_ch.free_address  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero-byte request, bad frees, zero-size remainder, split,
    // exact fit, oversize requests.
    issue(OP_ALLOC, 0, 0);
    issue(OP_FREE, 0, 0);
    issue(OP_FREE, 0, 1023);
    issue(OP_ALLOC, 16, 0);
    issue(OP_FREE, 0, 1);
    issue(OP_ALLOC, 8, 0);
    issue(OP_ALLOC, 1, 0);
    issue(OP_FREE, 0, 3);
    issue(OP_FREE, 0, 1);
    issue(OP_FREE, 0, 1);
    issue(OP_FREE, 0, 2);
    issue(OP_ALLOC, 8192, 0);
    issue(OP_ALLOC, 8191, 0);
    issue(OP_ALLOC, 8169, 0);
    issue(OP_ALLOC, 5, 0);
    issue(OP_ALLOC, 10, 0);
    issue(OP_ALLOC, 1000, 0);
    issue(OP_FREE, 0, 9);
    issue(OP_ALLOC, 8, 0);
    issue(OP_ALLOC, 984, 1023);
    issue(OP_FREE, 8191, 6);
    issue(OP_FREE, 0, 6);
    drain_replies();
    live_addrs.delete();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 700 && n < 1000);
      if (n == 1200) drain_replies();
      r = $urandom_range(99);
      if (r < 3) begin
        issue(OP_ALLOC, 0, $urandom_range(1023));
      end else if (r < 48 || (r < 92 && live_addrs.size() == 0)) begin
        k = $urandom_range(99);
        if (k < 80)      nbytes = $urandom_range(64, 1);
        else if (k < 95) nbytes = $urandom_range(1024, 65);
        else             nbytes = $urandom_range(8192, 1025);
        issue(OP_ALLOC, nbytes, $urandom_range(1023));
      end else if (r < 92) begin
        k = $urandom_range(live_addrs.size() - 1);
        last_freed = live_addrs[k];
        live_addrs.delete(k);
        issue(OP_FREE, $urandom_range(8192), last_freed);
      end else if (r < 96) begin
        issue(OP_FREE, $urandom_range(8192), $urandom_range(1023));
      end else begin
        // Free the same block twice, or one that has been granted again.
        issue(OP_FREE, $urandom_range(8192), last_freed);
      end
    end
    calm = 1'b0;
    drain_replies();
    repeat (2200) @(posedge clk);

    if (mismatches == 0) begin
      $display("** first_fit_heap_allocator: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_ram.sv
rtl/ffha_core.sv
rtl/ffha_out.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_chk.sv
bench/ffha_checker.sv
bench/testbench.sv
